FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is ignored while reset is high.
`define FCVU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that is also checked during reset.
`define FCVU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fcvu_pkg.sv
// Package for the fly camera view update core: codes, constants, helpers.
package fcvu_pkg;

   // Default parameter values
   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // Internal fixed-point formats
   localparam int ANG_FRAC   = 24;
   localparam int TRIG_FRAC  = 30;
   localparam int ATAN_COUNT = 24;
   localparam int CW         = 36;   // CORDIC x/y/z and angle width
   localparam int SQRT_STEPS = 32;
   localparam int CNTW       = 6;    // shared iteration counter

   localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
   localparam logic signed [CW-1:0] ANG_HALF    = 36'sd180 <<< ANG_FRAC;

   // Operation codes
   localparam logic [1:0] OP_MOVE    = 2'd0;
   localparam logic [1:0] OP_ROTATE  = 2'd1;
   localparam logic [1:0] OP_VIEW    = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   // Register indexes
   localparam logic [2:0] CSR_START_X  = 3'd0;
   localparam logic [2:0] CSR_START_Y  = 3'd1;
   localparam logic [2:0] CSR_START_Z  = 3'd2;
   localparam logic [2:0] CSR_TARGET_X = 3'd3;
   localparam logic [2:0] CSR_TARGET_Y = 3'd4;
   localparam logic [2:0] CSR_TARGET_Z = 3'd5;
   localparam logic [2:0] CSR_UP_HINT  = 3'd6;

   // Which basis vector a normalization writes
   localparam logic [1:0] NS_FRONT = 2'd0;
   localparam logic [1:0] NS_RIGHT = 2'd1;
   localparam logic [1:0] NS_UP    = 2'd2;

   typedef logic signed [31:0] q_type;

   // atan(2^-i) in degrees, 24 fraction bits
   function automatic logic [31:0] atan_deg(input logic [CNTW-1:0] i);
      logic [31:0] r;
      case (i)
         6'd0:  r = 32'd754974720;
         6'd1:  r = 32'd445687602;
         6'd2:  r = 32'd235489088;
         6'd3:  r = 32'd119537938;
         6'd4:  r = 32'd60000934;
         6'd5:  r = 32'd30029717;
         6'd6:  r = 32'd15018523;
         6'd7:  r = 32'd7509720;
         6'd8:  r = 32'd3754917;
         6'd9:  r = 32'd1877466;
         6'd10: r = 32'd938734;
         6'd11: r = 32'd469367;
         6'd12: r = 32'd234684;
         6'd13: r = 32'd117342;
         6'd14: r = 32'd58671;
         6'd15: r = 32'd29335;
         6'd16: r = 32'd14668;
         6'd17: r = 32'd7334;
         6'd18: r = 32'd3667;
         6'd19: r = 32'd1833;
         6'd20: r = 32'd917;
         6'd21: r = 32'd458;
         6'd22: r = 32'd229;
         6'd23: r = 32'd115;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // Cross product operand order: r[k/2] = sum of +/- a[ai]*b[bi]
   function automatic logic [1:0] cross_a_idx(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0: r = 2'd1;
         3'd1: r = 2'd2;
         3'd2: r = 2'd2;
         3'd3: r = 2'd0;
         3'd4: r = 2'd0;
         3'd5: r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] cross_b_idx(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0: r = 2'd2;
         3'd1: r = 2'd1;
         3'd2: r = 2'd0;
         3'd3: r = 2'd2;
         3'd4: r = 2'd1;
         3'd5: r = 2'd0;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   // Saturate to the signed 32-bit range
   function automatic q_type sat32(input logic signed [64:0] v);
      q_type r;
      if (v > 65'sd2147483647) r = 32'sh7fffffff;
      else if (v < -65'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

FILE: rtl/fly_camera_view_update_core.sv
// Fly camera view update core: move/rotate/restart of a camera basis and look-at rows.
//
// One item is in work at a time; req_stall is high from acceptance until the result has
// been loaded into the output register, and a new item may be taken while that result
// still waits on rsp_stall. Everything runs on one shared 34x34 multiplier and a few
// bit-serial units under a sequencer. Rotate and restart each run three normalizations
// (magnitude shift, 3 squares, 32-step square root, 3 restoring divisions), and rotate
// adds two CORDIC passes and the yaw wrap. The square root and divider of the normalizer
// set the run time of rotate and restart.
module fly_camera_view_update_core
   import fcvu_pkg::*;
#(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // item channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [1:0]         req_direction,
   input  logic signed [31:0] req_speed,
   input  logic signed [31:0] req_pitch,
   input  logic signed [31:0] req_yaw,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_row0_x,
   output logic signed [31:0] rsp_row0_y,
   output logic signed [31:0] rsp_row0_z,
   output logic signed [31:0] rsp_row0_w,
   output logic signed [31:0] rsp_row1_x,
   output logic signed [31:0] rsp_row1_y,
   output logic signed [31:0] rsp_row1_z,
   output logic signed [31:0] rsp_row1_w,
   output logic signed [31:0] rsp_row2_x,
   output logic signed [31:0] rsp_row2_y,
   output logic signed [31:0] rsp_row2_z,
   output logic signed [31:0] rsp_row2_w,
   // configuration
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata
);

   localparam int QW       = FRAC_BITS + 2;
   localparam int NSTEPS   = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
   localparam int ASH      = ANG_FRAC - FRAC_BITS;
   localparam q_type ONE_Q     = 32'sd1 <<< FRAC_BITS;
   localparam q_type PITCH_LIM = 32'sd89 <<< FRAC_BITS;
   localparam logic signed [63:0] RND_F = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] RND_T = 64'sd1 <<< (TRIG_FRAC - 1);
   localparam logic [63:0] FULL_DEG  = 64'd360 << FRAC_BITS;
   localparam logic [63:0] YAW_QMAX  = (64'd1 << 31) / FULL_DEG;
   localparam int YAW_STEPS = $clog2(YAW_QMAX + 64'd1) + 1;

   // Sequencer states
   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_MV_MUL   = 5'd1;
   localparam logic [4:0] ST_MV_ACC   = 5'd2;
   localparam logic [4:0] ST_YAW      = 5'd3;
   localparam logic [4:0] ST_CRD_INIT = 5'd4;
   localparam logic [4:0] ST_CRD_RUN  = 5'd5;
   localparam logic [4:0] ST_CRD_DONE = 5'd6;
   localparam logic [4:0] ST_FR_MUL   = 5'd7;
   localparam logic [4:0] ST_FR_ACC   = 5'd8;
   localparam logic [4:0] ST_N_ABS    = 5'd9;
   localparam logic [4:0] ST_N_SHIFT  = 5'd10;
   localparam logic [4:0] ST_N_MUL    = 5'd11;
   localparam logic [4:0] ST_N_ACC    = 5'd12;
   localparam logic [4:0] ST_N_SQRT   = 5'd13;
   localparam logic [4:0] ST_N_DINIT  = 5'd14;
   localparam logic [4:0] ST_N_DIV    = 5'd15;
   localparam logic [4:0] ST_X_MUL    = 5'd16;
   localparam logic [4:0] ST_X_ACC    = 5'd17;
   localparam logic [4:0] ST_D_MUL    = 5'd18;
   localparam logic [4:0] ST_D_ACC    = 5'd19;
   localparam logic [4:0] ST_DONE     = 5'd20;

   // Control
   logic [4:0]       state_ff, state_in;
   logic [2:0]       idx_ff, idx_in;
   logic [1:0]       row_ff, row_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic [1:0]       nsel_ff, nsel_in;
   logic             crd_sel_ff, crd_sel_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Configuration
   q_type            start_ff [3], start_in [3];
   q_type            target_ff [3], target_in [3];
   logic [47:0]      up_hint_ff, up_hint_in;

   // Camera state
   q_type            pos_ff [3], pos_in [3];
   q_type            front_ff [3], front_in [3];
   q_type            right_ff [3], right_in [3];
   q_type            up_ff [3], up_in [3];

   // Work registers
   logic [1:0]              dir_ff, dir_in;
   q_type                   speed_ff, speed_in;
   q_type                   pitch_ff, pitch_in;
   logic [33:0]             yr_ff, yr_in;
   logic                    yneg_ff, yneg_in;
   q_type                   hint_ff [3], hint_in [3];
   logic signed [CW-1:0]    cr_x_ff, cr_x_in, cr_y_ff, cr_y_in, cr_z_ff, cr_z_in;
   logic                    cr_neg_ff, cr_neg_in;
   logic signed [33:0]      cos_p_ff, cos_p_in, sin_p_ff, sin_p_in;
   logic signed [33:0]      cos_y_ff, cos_y_in, sin_y_ff, sin_y_in;
   logic signed [63:0]      vec_ff [3], vec_in [3];
   logic [63:0]             mag_ff [3], mag_in [3];
   logic signed [63:0]      prod_ff, prod_in;
   logic signed [63:0]      acc_ff, acc_in;
   logic [63:0]             sq_x_ff, sq_x_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [31:0]             root_ff, root_in;
   logic [31:0]             rem_ff, rem_in;
   logic [QW-1:0]           dlo_ff, dlo_in, quo_ff, quo_in;
   q_type                   w_ff [3], w_in [3];

   // Output register
   q_type   out_r0_ff [4], out_r0_in [4];
   q_type   out_r1_ff [4], out_r1_in [4];
   q_type   out_r2_ff [4], out_r2_in [4];

   // Shared multiplier
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_full;

   assign mul_full = mul_a * mul_b;
   assign prod_in  = mul_full[63:0];

   // Multiplier operand select
   always_comb begin
      q_type dsel;
      q_type xa;
      q_type xb;
      dsel  = '0;
      xa    = '0;
      xb    = '0;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MV_MUL: begin
            dsel  = dir_ff[1] ? right_ff[idx_ff[1:0]] : front_ff[idx_ff[1:0]];
            mul_a = dir_ff[0] ? -34'(dsel) : 34'(dsel);
            mul_b = 34'(speed_ff);
         end
         ST_FR_MUL: begin
            mul_a = cos_p_ff;
            mul_b = (idx_ff == 3'd0) ? cos_y_ff : sin_y_ff;
         end
         ST_N_MUL: begin
            mul_a = $signed({1'b0, mag_ff[idx_ff[1:0]][32:0]});
            mul_b = $signed({1'b0, mag_ff[idx_ff[1:0]][32:0]});
         end
         ST_X_MUL: begin
            if (nsel_ff == NS_RIGHT) begin
               xa = front_ff[cross_a_idx(idx_ff)];
               xb = hint_ff[cross_b_idx(idx_ff)];
            end else begin
               xa = right_ff[cross_a_idx(idx_ff)];
               xb = front_ff[cross_b_idx(idx_ff)];
            end
            mul_a = 34'(xa);
            mul_b = 34'(xb);
         end
         ST_D_MUL: begin
            case (row_ff)
               2'd0:    dsel = right_ff[idx_ff[1:0]];
               2'd1:    dsel = up_ff[idx_ff[1:0]];
               default: dsel = front_ff[idx_ff[1:0]];
            endcase
            mul_a = 34'(dsel);
            mul_b = 34'(pos_ff[idx_ff[1:0]]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer and datapath
   always_comb begin
      logic signed [63:0]   rnd;
      logic signed [64:0]   wide;
      logic [63:0]          ysh;
      logic [33:0]          yr_t;
      logic signed [CW-1:0] ang;
      logic signed [CW-1:0] ang_w;
      logic signed [CW-1:0] dxs;
      logic signed [CW-1:0] dys;
      logic signed [CW-1:0] atn;
      logic                 big;
      logic                 small_all;
      logic [63:0]          sq_t;
      logic [63:0]          sq_res_t;
      logic [63:0]          dvd;
      logic [32:0]          r2;
      logic                 qbit;
      logic [QW-1:0]        quo_t;
      q_type                qv;
      logic signed [63:0]   sum;

      rnd       = '0;
      wide      = '0;
      ysh       = '0;
      yr_t      = '0;
      ang       = '0;
      ang_w     = '0;
      dxs       = '0;
      dys       = '0;
      atn       = '0;
      big       = 1'b0;
      small_all = 1'b0;
      sq_t      = '0;
      sq_res_t  = '0;
      dvd       = '0;
      r2        = '0;
      qbit      = 1'b0;
      quo_t     = '0;
      qv        = '0;
      sum       = '0;

      state_in     = state_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      nsel_in      = nsel_ff;
      crd_sel_in   = crd_sel_ff;
      rsp_valid_in = rsp_valid_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      up_hint_in   = up_hint_ff;
      pos_in       = pos_ff;
      front_in     = front_ff;
      right_in     = right_ff;
      up_in        = up_ff;
      dir_in       = dir_ff;
      speed_in     = speed_ff;
      pitch_in     = pitch_ff;
      yr_in        = yr_ff;
      yneg_in      = yneg_ff;
      hint_in      = hint_ff;
      cr_x_in      = cr_x_ff;
      cr_y_in      = cr_y_ff;
      cr_z_in      = cr_z_ff;
      cr_neg_in    = cr_neg_ff;
      cos_p_in     = cos_p_ff;
      sin_p_in     = sin_p_ff;
      cos_y_in     = cos_y_ff;
      sin_y_in     = sin_y_ff;
      vec_in       = vec_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      sq_x_in      = sq_x_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      dlo_in       = dlo_ff;
      quo_in       = quo_ff;
      w_in         = w_ff;
      out_r0_in    = out_r0_ff;
      out_r1_in    = out_r1_ff;
      out_r2_in    = out_r2_ff;

      // result beat taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_X:  start_in[0]  = csr_wdata[31:0];
            CSR_START_Y:  start_in[1]  = csr_wdata[31:0];
            CSR_START_Z:  start_in[2]  = csr_wdata[31:0];
            CSR_TARGET_X: target_in[0] = csr_wdata[31:0];
            CSR_TARGET_Y: target_in[1] = csr_wdata[31:0];
            CSR_TARGET_Z: target_in[2] = csr_wdata[31:0];
            CSR_UP_HINT:  up_hint_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in = '0;
               row_in = '0;
               unique case (req_operation)
                  OP_MOVE: begin
                     dir_in   = req_direction;
                     speed_in = req_speed;
                     state_in = ST_MV_MUL;
                  end
                  OP_ROTATE: begin
                     if (req_pitch > PITCH_LIM) pitch_in = PITCH_LIM;
                     else if (req_pitch < -PITCH_LIM) pitch_in = -PITCH_LIM;
                     else pitch_in = req_pitch;
                     yneg_in    = req_yaw[31];
                     yr_in      = req_yaw[31] ? 34'(-33'(req_yaw)) : 34'(req_yaw);
                     cnt_in     = CNTW'(YAW_STEPS - 1);
                     hint_in[0] = '0;
                     hint_in[1] = ONE_Q;
                     hint_in[2] = '0;
                     crd_sel_in = 1'b0;
                     state_in   = ST_YAW;
                  end
                  OP_RESTART: begin
                     for (int i = 0; i < 3; i++) begin
                        pos_in[i] = start_ff[i];
                        vec_in[i] = 64'(target_ff[i]) - 64'(start_ff[i]);
                     end
                     hint_in[0] = 32'($signed(up_hint_ff[47:32]));
                     hint_in[1] = 32'($signed(up_hint_ff[31:16]));
                     hint_in[2] = 32'($signed(up_hint_ff[15:0]));
                     nsel_in    = NS_FRONT;
                     state_in   = ST_N_ABS;
                  end
                  default: state_in = ST_D_MUL;
               endcase
            end
         end

         // position += rounded(dir * speed)
         ST_MV_MUL: state_in = ST_MV_ACC;
         ST_MV_ACC: begin
            rnd  = (prod_ff + RND_F) >>> FRAC_BITS;
            wide = 65'(pos_ff[idx_ff[1:0]]) + 65'(rnd);
            pos_in[idx_ff[1:0]] = sat32(wide);
            if (idx_ff == 3'd2) begin
               idx_in   = '0;
               row_in   = '0;
               state_in = ST_D_MUL;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_MV_MUL;
            end
         end

         // yaw wrap into [0, 360): restoring reduction, one multiple per cycle
         ST_YAW: begin
            ysh  = FULL_DEG << cnt_ff;
            yr_t = yr_ff;
            if (64'(yr_ff) >= ysh) yr_t = yr_ff - ysh[33:0];
            yr_in = yr_t;
            if (cnt_ff == '0) begin
               if (yneg_ff && (yr_t != '0)) yr_in = FULL_DEG[33:0] - yr_t;
               state_in = ST_CRD_INIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         // CORDIC: fold angle to [-90, 90], preload gain
         ST_CRD_INIT: begin
            if (crd_sel_ff) ang = $signed(CW'(yr_ff) << ASH);
            else ang = CW'(pitch_ff) <<< ASH;
            ang_w = (ang > ANG_HALF) ? ang - (ANG_HALF <<< 1) : ang;
            cr_neg_in = 1'b0;
            if (ang_w > (ANG_HALF >>> 1)) begin
               ang_w     = ang_w - ANG_HALF;
               cr_neg_in = 1'b1;
            end else if (ang_w < -(ANG_HALF >>> 1)) begin
               ang_w     = ang_w + ANG_HALF;
               cr_neg_in = 1'b1;
            end
            cr_x_in  = CORDIC_GAIN;
            cr_y_in  = '0;
            cr_z_in  = ang_w;
            cnt_in   = '0;
            state_in = ST_CRD_RUN;
         end
         ST_CRD_RUN: begin
            dxs = cr_y_ff >>> cnt_ff;
            dys = cr_x_ff >>> cnt_ff;
            atn = CW'(atan_deg(cnt_ff));
            if (!cr_z_ff[CW-1]) begin
               cr_x_in = cr_x_ff - dxs;
               cr_y_in = cr_y_ff + dys;
               cr_z_in = cr_z_ff - atn;
            end else begin
               cr_x_in = cr_x_ff + dxs;
               cr_y_in = cr_y_ff - dys;
               cr_z_in = cr_z_ff + atn;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(NSTEPS - 1)) state_in = ST_CRD_DONE;
         end
         ST_CRD_DONE: begin
            if (!crd_sel_ff) begin
               cos_p_in   = cr_neg_ff ? -cr_x_ff[33:0] : cr_x_ff[33:0];
               sin_p_in   = cr_neg_ff ? -cr_y_ff[33:0] : cr_y_ff[33:0];
               crd_sel_in = 1'b1;
               state_in   = ST_CRD_INIT;
            end else begin
               cos_y_in  = cr_neg_ff ? -cr_x_ff[33:0] : cr_x_ff[33:0];
               sin_y_in  = cr_neg_ff ? -cr_y_ff[33:0] : cr_y_ff[33:0];
               vec_in[1] = 64'(sin_p_ff);
               idx_in    = '0;
               state_in  = ST_FR_MUL;
            end
         end

         // front before normalization: cp*cy and cp*sy
         ST_FR_MUL: state_in = ST_FR_ACC;
         ST_FR_ACC: begin
            rnd = (prod_ff + RND_T) >>> TRIG_FRAC;
            if (idx_ff == 3'd0) begin
               vec_in[0] = rnd;
               idx_in    = 3'd1;
               state_in  = ST_FR_MUL;
            end else begin
               vec_in[2] = rnd;
               nsel_in   = NS_FRONT;
               state_in  = ST_N_ABS;
            end
         end

         // normalize: magnitudes, zero rule
         ST_N_ABS: begin
            for (int i = 0; i < 3; i++)
               mag_in[i] = vec_ff[i][63] ? 64'(-vec_ff[i]) : 64'(vec_ff[i]);
            if ((vec_ff[0] == '0) && (vec_ff[1] == '0) && (vec_ff[2] == '0)) begin
               for (int i = 0; i < 3; i++) begin
                  unique case (nsel_ff)
                     NS_FRONT: front_in[i] = '0;
                     NS_RIGHT: right_in[i] = '0;
                     default:  up_in[i]    = '0;
                  endcase
               end
               idx_in = '0;
               row_in = '0;
               unique case (nsel_ff)
                  NS_FRONT: begin
                     nsel_in  = NS_RIGHT;
                     state_in = ST_X_MUL;
                  end
                  NS_RIGHT: begin
                     nsel_in  = NS_UP;
                     state_in = ST_X_MUL;
                  end
                  default: state_in = ST_D_MUL;
               endcase
            end else begin
               state_in = ST_N_SHIFT;
            end
         end
         // one bit per cycle until the largest lies in [2^29, 2^30)
         ST_N_SHIFT: begin
            big       = (mag_ff[0][63:30] != '0) || (mag_ff[1][63:30] != '0)
                        || (mag_ff[2][63:30] != '0);
            small_all = (mag_ff[0][63:29] == '0) && (mag_ff[1][63:29] == '0)
                        && (mag_ff[2][63:29] == '0);
            if (big) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (small_all) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               idx_in   = '0;
               acc_in   = '0;
               state_in = ST_N_MUL;
            end
         end
         // sum of squares
         ST_N_MUL: state_in = ST_N_ACC;
         ST_N_ACC: begin
            sum    = acc_ff + prod_ff;
            acc_in = sum;
            if (idx_ff == 3'd2) begin
               sq_x_in   = sum;
               sq_res_in = '0;
               sq_bit_in = 64'd1 << 62;
               cnt_in    = '0;
               state_in  = ST_N_SQRT;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_N_MUL;
            end
         end
         // integer square root, one result bit per step
         ST_N_SQRT: begin
            sq_t = sq_res_ff + sq_bit_ff;
            if (sq_x_ff >= sq_t) begin
               sq_x_in  = sq_x_ff - sq_t;
               sq_res_t = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_t = sq_res_ff >> 1;
            end
            sq_res_in = sq_res_t;
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(SQRT_STEPS - 1)) begin
               root_in  = sq_res_t[31:0];
               idx_in   = '0;
               state_in = ST_N_DINIT;
            end
         end
         // rounded quotient (m << F + n/2) / n, restoring
         ST_N_DINIT: begin
            dvd      = (mag_ff[idx_ff[1:0]] << FRAC_BITS) + 64'(root_ff >> 1);
            rem_in   = dvd[QW+31:QW];
            dlo_in   = dvd[QW-1:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_N_DIV;
         end
         ST_N_DIV: begin
            r2     = {rem_ff, dlo_ff[QW-1]};
            dlo_in = dlo_ff << 1;
            if (r2 >= {1'b0, root_ff}) begin
               r2   = r2 - {1'b0, root_ff};
               qbit = 1'b1;
            end
            rem_in = r2[31:0];
            quo_t  = {quo_ff[QW-2:0], qbit};
            quo_in = quo_t;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(QW - 1)) begin
               qv = vec_ff[idx_ff[1:0]][63] ? -32'(quo_t) : 32'(quo_t);
               unique case (nsel_ff)
                  NS_FRONT: front_in[idx_ff[1:0]] = qv;
                  NS_RIGHT: right_in[idx_ff[1:0]] = qv;
                  default:  up_in[idx_ff[1:0]]    = qv;
               endcase
               if (idx_ff == 3'd2) begin
                  idx_in = '0;
                  row_in = '0;
                  unique case (nsel_ff)
                     NS_FRONT: begin
                        nsel_in  = NS_RIGHT;
                        state_in = ST_X_MUL;
                     end
                     NS_RIGHT: begin
                        nsel_in  = NS_UP;
                        state_in = ST_X_MUL;
                     end
                     default: state_in = ST_D_MUL;
                  endcase
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = ST_N_DINIT;
               end
            end
         end

         // cross product, six products
         ST_X_MUL: state_in = ST_X_ACC;
         ST_X_ACC: begin
            if (!idx_ff[0]) vec_in[idx_ff[2:1]] = prod_ff;
            else vec_in[idx_ff[2:1]] = vec_ff[idx_ff[2:1]] - prod_ff;
            if (idx_ff == 3'd5) begin
               state_in = ST_N_ABS;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_X_MUL;
            end
         end

         // translation terms
         ST_D_MUL: state_in = ST_D_ACC;
         ST_D_ACC: begin
            sum    = ((idx_ff == 3'd0) ? 64'sd0 : acc_ff) + prod_ff;
            acc_in = sum;
            if (idx_ff == 3'd2) begin
               rnd = (sum + RND_F) >>> FRAC_BITS;
               if (row_ff == 2'd2) w_in[row_ff] = sat32(65'(rnd));
               else w_in[row_ff] = sat32(-65'(rnd));
               idx_in = '0;
               if (row_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = ST_D_MUL;
               end
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_D_MUL;
            end
         end

         // load the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               for (int i = 0; i < 3; i++) begin
                  out_r0_in[i] = right_ff[i];
                  out_r1_in[i] = up_ff[i];
                  out_r2_in[i] = -front_ff[i];
               end
               out_r0_in[3] = w_ff[0];
               out_r1_in[3] = w_ff[1];
               out_r2_in[3] = w_ff[2];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         nsel_ff      <= NS_FRONT;
         crd_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            start_ff[i]  <= '0;
            target_ff[i] <= '0;
            pos_ff[i]    <= '0;
            front_ff[i]  <= '0;
            right_ff[i]  <= '0;
            up_ff[i]     <= '0;
         end
         target_ff[2] <= -ONE_Q;
         up_hint_ff   <= 48'h0000_4000_0000;
         front_ff[2]  <= -ONE_Q;
         right_ff[0]  <= ONE_Q;
         up_ff[1]     <= ONE_Q;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         nsel_ff      <= nsel_in;
         crd_sel_ff   <= crd_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         target_ff    <= target_in;
         up_hint_ff   <= up_hint_in;
         pos_ff       <= pos_in;
         front_ff     <= front_in;
         right_ff     <= right_in;
         up_ff        <= up_in;
      end
      // payload
      dir_ff    <= dir_in;
      speed_ff  <= speed_in;
      pitch_ff  <= pitch_in;
      yr_ff     <= yr_in;
      yneg_ff   <= yneg_in;
      hint_ff   <= hint_in;
      cr_x_ff   <= cr_x_in;
      cr_y_ff   <= cr_y_in;
      cr_z_ff   <= cr_z_in;
      cr_neg_ff <= cr_neg_in;
      cos_p_ff  <= cos_p_in;
      sin_p_ff  <= sin_p_in;
      cos_y_ff  <= cos_y_in;
      sin_y_ff  <= sin_y_in;
      vec_ff    <= vec_in;
      mag_ff    <= mag_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      sq_x_ff   <= sq_x_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      root_ff   <= root_in;
      rem_ff    <= rem_in;
      dlo_ff    <= dlo_in;
      quo_ff    <= quo_in;
      w_ff      <= w_in;
      out_r0_ff <= out_r0_in;
      out_r1_ff <= out_r1_in;
      out_r2_ff <= out_r2_in;
   end

   // Ports
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_row0_x = out_r0_ff[0];
   assign rsp_row0_y = out_r0_ff[1];
   assign rsp_row0_z = out_r0_ff[2];
   assign rsp_row0_w = out_r0_ff[3];
   assign rsp_row1_x = out_r1_ff[0];
   assign rsp_row1_y = out_r1_ff[1];
   assign rsp_row1_z = out_r1_ff[2];
   assign rsp_row1_w = out_r1_ff[3];
   assign rsp_row2_x = out_r2_ff[0];
   assign rsp_row2_y = out_r2_ff[1];
   assign rsp_row2_z = out_r2_ff[2];
   assign rsp_row2_w = out_r2_ff[3];

endmodule

FILE: rtl/fcvu_chk.sv
// Port-level checker for the fly camera view update core, with its bind.
`include "assert_macros.svh"

module fcvu_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_row0_x
);

   // stalled result beat stays
   `FCVU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp beat dropped")
   `FCVU_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_row0_x), "rsp payload moved")
   // an accepted item keeps the block busy for the next cycle
   `FCVU_ASSERT(a_busy, clock, reset, req_valid && !req_stall |=> req_stall, "not busy after accept")
   // no result can appear in the cycle after the block sat idle and empty
   `FCVU_ASSERT(a_no_early, clock, reset, !req_stall && !rsp_valid |=> !rsp_valid, "result too early")
   // reset leaves the block idle and empty
   `FCVU_ASSERT_ALWAYS(a_reset, clock, $past(reset) |-> !rsp_valid && !req_stall, "bad reset state")

endmodule

bind fly_camera_view_update_core fcvu_chk u_fcvu_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_row0_x (rsp_row0_x)
);
